@@ hw/rtl/dual_stack_machine_core_macros.svh @@
// Assertion macros for the dual stack machine core.
// Used by the top level only; needs nothing else.
`ifndef DUAL_STACK_MACHINE_CORE_MACROS_SVH
`define DUAL_STACK_MACHINE_CORE_MACROS_SVH

// Same-cycle implication under an active-low reset.
`define DSM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication under an active-low reset.
`define DSM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/dsm_pkg.sv @@
// Shared types, codes and decode tables of the dual stack machine core.
// No dependencies.
`default_nettype none
package dsm_pkg;

    localparam int MEMORY_WORDS_DEF = 16384;
    localparam int DATA_DEPTH_DEF   = 32;
    localparam int RETURN_DEPTH_DEF = 128;
    localparam int WORD_BITS_DEF    = 32;

    // item commands
    localparam logic [1:0] CMD_LOAD    = 2'd0;
    localparam logic [1:0] CMD_EXEC    = 2'd1;
    localparam logic [1:0] CMD_RESTART = 2'd2;

    // result status
    localparam logic [3:0] ST_OK       = 4'd0;
    localparam logic [3:0] ST_LOADED   = 4'd1;
    localparam logic [3:0] ST_ENDED    = 4'd2;
    localparam logic [3:0] ST_UNDER    = 4'd3;
    localparam logic [3:0] ST_OVER     = 4'd4;
    localparam logic [3:0] ST_RET_ERR  = 4'd5;
    localparam logic [3:0] ST_DIV_ZERO = 4'd6;
    localparam logic [3:0] ST_BAD_ADDR = 4'd7;
    localparam logic [3:0] ST_BAD_OP   = 4'd8;
    localparam logic [3:0] ST_HALTED   = 4'd9;

    // instruction set
    localparam logic [4:0] OP_NOP    = 5'd0;
    localparam logic [4:0] OP_LIT    = 5'd1;
    localparam logic [4:0] OP_DUP    = 5'd2;
    localparam logic [4:0] OP_DROP   = 5'd3;
    localparam logic [4:0] OP_SWAP   = 5'd4;
    localparam logic [4:0] OP_PUSH   = 5'd5;
    localparam logic [4:0] OP_POP    = 5'd6;
    localparam logic [4:0] OP_JUMP   = 5'd7;
    localparam logic [4:0] OP_CALL   = 5'd8;
    localparam logic [4:0] OP_IF     = 5'd9;
    localparam logic [4:0] OP_RETURN = 5'd10;
    localparam logic [4:0] OP_EQ     = 5'd11;
    localparam logic [4:0] OP_NEQ    = 5'd12;
    localparam logic [4:0] OP_LT     = 5'd13;
    localparam logic [4:0] OP_GT     = 5'd14;
    localparam logic [4:0] OP_FETCH  = 5'd15;
    localparam logic [4:0] OP_STORE  = 5'd16;
    localparam logic [4:0] OP_ADD    = 5'd17;
    localparam logic [4:0] OP_SUB    = 5'd18;
    localparam logic [4:0] OP_MUL    = 5'd19;
    localparam logic [4:0] OP_DIVMOD = 5'd20;
    localparam logic [4:0] OP_AND    = 5'd21;
    localparam logic [4:0] OP_OR     = 5'd22;
    localparam logic [4:0] OP_XOR    = 5'd23;
    localparam logic [4:0] OP_SHIFT  = 5'd24;
    localparam logic [4:0] OP_ZRET   = 5'd25;
    localparam logic [4:0] OP_END    = 5'd26;

    typedef enum logic [3:0] {
        ALU_ADD, ALU_SUB, ALU_EQ, ALU_NEQ, ALU_LT, ALU_GT,
        ALU_AND, ALU_OR, ALU_XOR, ALU_SHIFT, ALU_MUL, ALU_DIV
    } alu_op_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } alu_stat_t;

    // data stack entries an opcode needs
    function automatic logic [1:0] need_data(input logic [4:0] op);
        logic [1:0] n;
        begin
            unique case (op)
                OP_NOP, OP_LIT, OP_POP, OP_RETURN, OP_END: n = 2'd0;
                OP_DUP, OP_DROP, OP_PUSH, OP_JUMP, OP_CALL,
                OP_FETCH, OP_ZRET: n = 2'd1;
                OP_IF: n = 2'd3;
                default: n = 2'd2;
            endcase
            return n;
        end
    endfunction

    function automatic alu_op_t alu_op_of(input logic [4:0] op);
        alu_op_t a;
        begin
            unique case (op)
                OP_SUB:    a = ALU_SUB;
                OP_EQ:     a = ALU_EQ;
                OP_NEQ:    a = ALU_NEQ;
                OP_LT:     a = ALU_LT;
                OP_GT:     a = ALU_GT;
                OP_AND:    a = ALU_AND;
                OP_OR:     a = ALU_OR;
                OP_XOR:    a = ALU_XOR;
                OP_SHIFT:  a = ALU_SHIFT;
                OP_MUL:    a = ALU_MUL;
                OP_DIVMOD: a = ALU_DIV;
                default:   a = ALU_ADD;
            endcase
            return a;
        end
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/dsm_ram.sv @@
// Single write port, single registered read port memory.
// Generic; no dependencies.
`default_nettype none
module dsm_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

@@ hw/rtl/dsm_alu.sv @@
// Shared arithmetic unit: combinational add/compare/logic/shift,
// bit-serial multiply and restoring divide. Uses dsm_pkg.
`default_nettype none
module dsm_alu #(
    parameter int WORD_BITS = dsm_pkg::WORD_BITS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire dsm_pkg::alu_ctl_t    ctl,
    input  wire logic [WORD_BITS-1:0] a,
    input  wire logic [WORD_BITS-1:0] b,
    output logic      [WORD_BITS-1:0] result,
    output logic      [WORD_BITS-1:0] result_hi,
    output dsm_pkg::alu_stat_t        stat
);

    localparam int CW = $clog2(WORD_BITS + 1);

    logic              busy_reg, done_reg, div_reg, negq_reg, negr_reg;
    logic [CW-1:0]     cnt_reg;
    logic [WORD_BITS-1:0] acc_reg, acc_next, x_reg, x_next, y_reg, y_next;
    logic [WORD_BITS-1:0] simple, neg_b, abs_a, abs_b;
    logic [WORD_BITS:0]   rem_sh, diff;
    logic                 is_long;

    assign neg_b = WORD_BITS'(0) - b;
    assign abs_a = a[WORD_BITS-1] ? WORD_BITS'(0) - a : a;
    assign abs_b = b[WORD_BITS-1] ? neg_b : b;
    assign is_long = (ctl.op == dsm_pkg::ALU_MUL) || (ctl.op == dsm_pkg::ALU_DIV);

    always_comb
    begin
        unique case (ctl.op)
            dsm_pkg::ALU_SUB: simple = a - b;
            dsm_pkg::ALU_EQ:  simple = {WORD_BITS{a == b}};
            dsm_pkg::ALU_NEQ: simple = {WORD_BITS{a != b}};
            dsm_pkg::ALU_LT:  simple = {WORD_BITS{$signed(a) < $signed(b)}};
            dsm_pkg::ALU_GT:  simple = {WORD_BITS{$signed(b) < $signed(a)}};
            dsm_pkg::ALU_AND: simple = a & b;
            dsm_pkg::ALU_OR:  simple = a | b;
            dsm_pkg::ALU_XOR: simple = a ^ b;
            dsm_pkg::ALU_SHIFT:
            begin
                // negative amount shifts left, otherwise arithmetic right
                if (b[WORD_BITS-1])
                    simple = (neg_b >= WORD_BITS'(WORD_BITS)) ? '0 : a << neg_b;
                else if (b >= WORD_BITS'(WORD_BITS))
                    simple = {WORD_BITS{a[WORD_BITS-1]}};
                else
                    simple = WORD_BITS'($signed(a) >>> b);
            end
            default: simple = a + b;
        endcase
    end

    // one divide or multiply step per cycle
    assign rem_sh = {acc_reg, x_reg[WORD_BITS-1]};
    assign diff   = rem_sh - {1'b0, y_reg};

    always_comb
    begin
        if (div_reg)
        begin
            acc_next = diff[WORD_BITS] ? rem_sh[WORD_BITS-1:0] : diff[WORD_BITS-1:0];
            x_next   = {x_reg[WORD_BITS-2:0], !diff[WORD_BITS]};
            y_next   = y_reg;
        end
        else
        begin
            acc_next = acc_reg + (y_reg[0] ? x_reg : '0);
            x_next   = {x_reg[WORD_BITS-2:0], 1'b0};
            y_next   = {1'b0, y_reg[WORD_BITS-1:1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl.start && is_long)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(WORD_BITS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start && is_long)
        begin
            div_reg  <= (ctl.op == dsm_pkg::ALU_DIV);
            negq_reg <= a[WORD_BITS-1] ^ b[WORD_BITS-1];
            negr_reg <= a[WORD_BITS-1];
            acc_reg  <= '0;
            x_reg    <= (ctl.op == dsm_pkg::ALU_DIV) ? abs_a : a;
            y_reg    <= (ctl.op == dsm_pkg::ALU_DIV) ? abs_b : b;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
            x_reg   <= x_next;
            y_reg   <= y_next;
        end
    end

    always_comb
    begin
        if (ctl.op == dsm_pkg::ALU_MUL)
            result = acc_reg;
        else if (ctl.op == dsm_pkg::ALU_DIV)
            result = negq_reg ? WORD_BITS'(0) - x_reg : x_reg;
        else
            result = simple;
    end

    assign result_hi = negr_reg ? WORD_BITS'(0) - acc_reg : acc_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule
`default_nettype wire

@@ hw/rtl/dual_stack_machine_core.sv @@
// Dual stack machine core: item sequencer, program memory, both stacks.
// Uses dsm_pkg, dsm_ram, dsm_alu and the assertion macro header.
//
// One item is taken when start is high and busy is low; its result shows for one
// cycle with done high and cannot be held off. After reset the core sweeps the
// program memory to zero with busy high. A load, restart, unused command or
// halted execute passes through S_TOP0 and S_TOP1 before its result shows. An
// execute reads the instruction and up to three stack cells and two memory words
// through the single read port of each memory, then writes up to three stack cells
// one per cycle in S_W1 to S_W3; a fault or END skips the writes. MUL and DIVMOD
// first wait in S_ALU for the bit-serial arithmetic unit.
`default_nettype none
`include "dual_stack_machine_core_macros.svh"
module dual_stack_machine_core #(
    parameter int MEMORY_WORDS = dsm_pkg::MEMORY_WORDS_DEF,
    parameter int DATA_DEPTH   = dsm_pkg::DATA_DEPTH_DEF,
    parameter int RETURN_DEPTH = dsm_pkg::RETURN_DEPTH_DEF,
    parameter int WORD_BITS    = dsm_pkg::WORD_BITS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [1:0]         opcode,
    input  wire logic [13:0]        load_address,
    input  wire logic signed [31:0] load_word,
    output logic                    done,
    output logic [3:0]              status,
    output logic [7:0]              executed_opcode,
    output logic [13:0]             next_ip,
    output logic signed [31:0]      top_of_stack,
    output logic [5:0]              data_depth,
    output logic [7:0]              return_depth
);

    localparam int AW  = $clog2(MEMORY_WORDS);
    localparam int DPW = $clog2(DATA_DEPTH + 1);
    localparam int RPW = $clog2(RETURN_DEPTH + 1);
    localparam int W   = WORD_BITS;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_F0    = 4'd2;
    localparam logic [3:0] S_F1    = 4'd3;
    localparam logic [3:0] S_F2    = 4'd4;
    localparam logic [3:0] S_F3    = 4'd5;
    localparam logic [3:0] S_DEC   = 4'd6;
    localparam logic [3:0] S_ALU   = 4'd7;
    localparam logic [3:0] S_W1    = 4'd8;
    localparam logic [3:0] S_W2    = 4'd9;
    localparam logic [3:0] S_W3    = 4'd10;
    localparam logic [3:0] S_TOP0  = 4'd11;
    localparam logic [3:0] S_TOP1  = 4'd12;

    logic [3:0]     state_reg, state_next;
    logic [AW-1:0]  clr_reg, ip_reg;
    logic [DPW-1:0] dp_reg;
    logic [RPW-1:0] rp_reg;
    logic           halted_reg, done_reg;
    logic [3:0]     status_reg;
    logic [7:0]     opbyte_reg;
    logic [W-1:0]   instr_reg, tos_reg, nos_reg, third_reg, lit_reg, rtop_reg, fetch_reg;
    logic [W-1:0]   top_reg;

    // planned writes of one instruction
    logic [DPW-1:0] dwa_reg [3];
    logic [W-1:0]   dwd_reg [3];
    logic [2:0]     dwe_reg;
    logic           rwe_reg, pwe_reg;
    logic [RPW-1:0] rwa_reg;
    logic [W-1:0]   rwd_reg, pwd_reg;
    logic [AW-1:0]  pwa_reg;

    // memory ports
    logic           pm_we, ds_we, rs_we;
    logic [AW-1:0]  pm_wa, pm_ra;
    logic [W-1:0]   pm_wd, pm_q, ds_wd, ds_q, rs_q;
    logic [DPW-1:0] ds_wa, ds_ra;

    dsm_pkg::alu_ctl_t  alu_ctl;
    dsm_pkg::alu_stat_t alu_stat;
    logic [W-1:0]       alu_res, alu_res_hi;

    logic           load_ok;
    logic [W-1:0]   load_ext;
    logic [DPW-1:0] s_m1, s_m2, s_p1;
    logic [4:0]     op;

    // decode results
    logic           d_err, d_end, d_long, d_jump, d_zret;
    logic [3:0]     d_status;
    logic [W-1:0]   d_target;
    logic [AW:0]    d_nip;
    logic [AW-1:0]  d_ip;
    logic [DPW-1:0] d_dp;
    logic [RPW-1:0] d_rp;
    logic [DPW-1:0] d_wa [3];
    logic [W-1:0]   d_wd [3];
    logic [2:0]     d_we;

    function automatic logic addr_ok(input logic [W-1:0] v);
        return !v[W-1] && (65'(v) < 65'(MEMORY_WORDS));
    endfunction

    assign load_ok  = 32'(load_address) < 32'(MEMORY_WORDS);
    assign load_ext = W'(load_word);
    assign s_m1     = dp_reg - DPW'(1);
    assign s_m2     = dp_reg - DPW'(2);
    assign s_p1     = dp_reg + DPW'(1);
    assign op       = instr_reg[4:0];

    dsm_ram #(.DEPTH(MEMORY_WORDS), .WIDTH(W)) u_pmem (
        .clk(clk), .we(pm_we), .waddr(pm_wa), .wdata(pm_wd), .raddr(pm_ra), .rdata(pm_q)
    );

    dsm_ram #(.DEPTH(DATA_DEPTH + 1), .WIDTH(W)) u_dstack (
        .clk(clk), .we(ds_we), .waddr(ds_wa), .wdata(ds_wd), .raddr(ds_ra), .rdata(ds_q)
    );

    dsm_ram #(.DEPTH(RETURN_DEPTH + 1), .WIDTH(W)) u_rstack (
        .clk(clk), .we(rs_we), .waddr(rwa_reg), .wdata(rwd_reg), .raddr(rp_reg),
        .rdata(rs_q)
    );

    assign alu_ctl.start = (state_reg == S_DEC) && !d_err && d_long;
    assign alu_ctl.op    = dsm_pkg::alu_op_of(op);

    dsm_alu #(.WORD_BITS(W)) u_alu (
        .clk(clk), .rst_n(rst_n), .ctl(alu_ctl), .a(nos_reg), .b(tos_reg),
        .result(alu_res), .result_hi(alu_res_hi), .stat(alu_stat)
    );

    // memory port muxing
    always_comb
    begin
        pm_we = 1'b0;
        pm_wa = clr_reg;
        pm_wd = '0;
        if (state_reg == S_CLEAR)
            pm_we = 1'b1;
        else if (state_reg == S_IDLE && start && opcode == dsm_pkg::CMD_LOAD && load_ok)
        begin
            pm_we = 1'b1;
            pm_wa = AW'(load_address);
            pm_wd = load_ext;
        end
        else if (state_reg == S_W1 && pwe_reg)
        begin
            pm_we = 1'b1;
            pm_wa = pwa_reg;
            pm_wd = pwd_reg;
        end

        unique case (state_reg)
            S_F1:    pm_ra = ip_reg + AW'(1);
            S_F2:    pm_ra = AW'(tos_reg);
            default: pm_ra = ip_reg;
        endcase

        unique case (state_reg)
            S_F1:    ds_ra = s_m1;
            S_F2:    ds_ra = s_m2;
            default: ds_ra = dp_reg;
        endcase

        ds_we = 1'b0;
        ds_wa = dwa_reg[0];
        ds_wd = dwd_reg[0];
        if (state_reg == S_W1)
            ds_we = dwe_reg[0];
        else if (state_reg == S_W2)
        begin
            ds_we = dwe_reg[1];
            ds_wa = dwa_reg[1];
            ds_wd = dwd_reg[1];
        end
        else if (state_reg == S_W3)
        begin
            ds_we = dwe_reg[2];
            ds_wa = dwa_reg[2];
            ds_wd = dwd_reg[2];
        end
        rs_we = (state_reg == S_W1) && rwe_reg;
    end

    // instruction decode and fault checks
    always_comb
    begin
        d_zret   = (op == dsm_pkg::OP_ZRET) && (tos_reg == '0) && (dp_reg != '0);
        d_long   = (op == dsm_pkg::OP_MUL) || (op == dsm_pkg::OP_DIVMOD);
        d_jump   = (op == dsm_pkg::OP_JUMP) || (op == dsm_pkg::OP_CALL)
                || (op == dsm_pkg::OP_IF) || (op == dsm_pkg::OP_RETURN) || d_zret;
        if (op == dsm_pkg::OP_IF)
            d_target = (third_reg != '0) ? nos_reg : tos_reg;
        else if (op == dsm_pkg::OP_RETURN || d_zret)
            d_target = rtop_reg + W'(1);
        else
            d_target = tos_reg;
        d_nip = {1'b0, ip_reg} + ((op == dsm_pkg::OP_LIT) ? (AW+1)'(2) : (AW+1)'(1));

        d_err    = 1'b1;
        d_end    = 1'b0;
        d_status = dsm_pkg::ST_OK;
        priority if (instr_reg > W'(dsm_pkg::OP_END))
            d_status = dsm_pkg::ST_BAD_OP;
        else if (dp_reg < DPW'(dsm_pkg::need_data(op)))
            d_status = dsm_pkg::ST_UNDER;
        else if (rp_reg == '0 && (op == dsm_pkg::OP_POP || op == dsm_pkg::OP_RETURN
                                  || d_zret))
            d_status = dsm_pkg::ST_RET_ERR;
        else if (dp_reg == DPW'(DATA_DEPTH) && (op == dsm_pkg::OP_LIT
                 || op == dsm_pkg::OP_DUP || op == dsm_pkg::OP_POP))
            d_status = dsm_pkg::ST_OVER;
        else if (rp_reg == RPW'(RETURN_DEPTH) && (op == dsm_pkg::OP_PUSH
                 || op == dsm_pkg::OP_CALL || op == dsm_pkg::OP_IF))
            d_status = dsm_pkg::ST_RET_ERR;
        else if (op == dsm_pkg::OP_DIVMOD && tos_reg == '0)
            d_status = dsm_pkg::ST_DIV_ZERO;
        else if (op == dsm_pkg::OP_LIT && ip_reg == AW'(MEMORY_WORDS - 1))
            d_status = dsm_pkg::ST_BAD_ADDR;
        else if ((op == dsm_pkg::OP_FETCH || op == dsm_pkg::OP_STORE) && !addr_ok(tos_reg))
            d_status = dsm_pkg::ST_BAD_ADDR;
        else if (d_jump && !addr_ok(d_target))
            d_status = dsm_pkg::ST_BAD_ADDR;
        else if (op == dsm_pkg::OP_END)
        begin
            d_err    = 1'b0;
            d_end    = 1'b1;
            d_status = dsm_pkg::ST_ENDED;
        end
        else
        begin
            d_err = 1'b0;
            // running off the end of memory halts after the step
            if (!d_jump && d_nip >= (AW+1)'(MEMORY_WORDS))
            begin
                d_end    = 1'b1;
                d_status = dsm_pkg::ST_ENDED;
            end
        end

        if (d_jump)
            d_ip = AW'(d_target);
        else if (d_end)
            d_ip = ip_reg;
        else
            d_ip = d_nip[AW-1:0];

        d_we = 3'b000;
        d_wa[0] = dp_reg;
        d_wa[1] = s_m1;
        d_wa[2] = s_m2;
        d_wd[0] = '0;
        d_wd[1] = '0;
        d_wd[2] = '0;
        d_dp = dp_reg;
        d_rp = rp_reg;
        unique case (op)
            dsm_pkg::OP_LIT:
            begin
                d_we = 3'b001; d_wa[0] = s_p1; d_wd[0] = lit_reg; d_dp = s_p1;
            end
            dsm_pkg::OP_DUP:
            begin
                d_we = 3'b001; d_wa[0] = s_p1; d_wd[0] = tos_reg; d_dp = s_p1;
            end
            dsm_pkg::OP_POP:
            begin
                d_we = 3'b001; d_wa[0] = s_p1; d_wd[0] = rtop_reg; d_dp = s_p1;
                d_rp = rp_reg - RPW'(1);
            end
            dsm_pkg::OP_DROP, dsm_pkg::OP_JUMP:
            begin
                d_we = 3'b001; d_dp = s_m1;
            end
            dsm_pkg::OP_PUSH, dsm_pkg::OP_CALL:
            begin
                d_we = 3'b001; d_dp = s_m1; d_rp = rp_reg + RPW'(1);
            end
            dsm_pkg::OP_IF:
            begin
                d_we = 3'b111; d_dp = dp_reg - DPW'(3); d_rp = rp_reg + RPW'(1);
            end
            dsm_pkg::OP_RETURN:
                d_rp = rp_reg - RPW'(1);
            dsm_pkg::OP_ZRET:
            begin
                if (d_zret)
                begin
                    d_we = 3'b001; d_dp = s_m1; d_rp = rp_reg - RPW'(1);
                end
            end
            dsm_pkg::OP_SWAP:
            begin
                d_we = 3'b011; d_wd[0] = nos_reg; d_wd[1] = tos_reg;
            end
            dsm_pkg::OP_FETCH:
            begin
                d_we = 3'b001; d_wd[0] = fetch_reg;
            end
            dsm_pkg::OP_STORE:
            begin
                d_we = 3'b011; d_dp = s_m2;
            end
            dsm_pkg::OP_DIVMOD:
                d_we = 3'b011;
            dsm_pkg::OP_EQ, dsm_pkg::OP_NEQ, dsm_pkg::OP_LT, dsm_pkg::OP_GT,
            dsm_pkg::OP_ADD, dsm_pkg::OP_SUB, dsm_pkg::OP_MUL, dsm_pkg::OP_AND,
            dsm_pkg::OP_OR, dsm_pkg::OP_XOR, dsm_pkg::OP_SHIFT:
            begin
                // result lands in NOS, the vacated TOS cell is cleared
                d_we = 3'b011; d_wa[0] = s_m1; d_wa[1] = dp_reg; d_wd[0] = alu_res;
                d_dp = s_m1;
            end
            default:
                d_we = 3'b000;
        endcase
        if (d_end && op == dsm_pkg::OP_END)
            d_we = 3'b000;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: if (clr_reg == AW'(MEMORY_WORDS - 1)) state_next = S_IDLE;
            S_IDLE:
            begin
                if (start)
                    state_next = (opcode == dsm_pkg::CMD_EXEC && !halted_reg) ? S_F0 : S_TOP0;
            end
            S_F0:  state_next = S_F1;
            S_F1:  state_next = S_F2;
            S_F2:  state_next = S_F3;
            S_F3:  state_next = S_DEC;
            S_DEC:
            begin
                if (d_err || (d_end && op == dsm_pkg::OP_END))
                    state_next = S_TOP0;
                else
                    state_next = d_long ? S_ALU : S_W1;
            end
            S_ALU: if (alu_stat.done) state_next = S_W1;
            S_W1:  state_next = S_W2;
            S_W2:  state_next = S_W3;
            S_W3:  state_next = S_TOP0;
            S_TOP0: state_next = S_TOP1;
            S_TOP1: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            clr_reg    <= '0;
            ip_reg     <= '0;
            dp_reg     <= '0;
            rp_reg     <= '0;
            halted_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == S_TOP1);
            if (state_reg == S_CLEAR)
                clr_reg <= clr_reg + AW'(1);
            if (state_reg == S_IDLE && start)
            begin
                if (opcode == dsm_pkg::CMD_RESTART)
                begin
                    ip_reg     <= '0;
                    dp_reg     <= '0;
                    rp_reg     <= '0;
                    halted_reg <= 1'b0;
                end
            end
            if (state_reg == S_DEC)
            begin
                if (d_err || d_end)
                    halted_reg <= 1'b1;
                if (!d_err)
                begin
                    ip_reg <= d_ip;
                    dp_reg <= d_dp;
                    rp_reg <= d_rp;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            opbyte_reg <= '0;
            if (opcode == dsm_pkg::CMD_LOAD)
                status_reg <= load_ok ? dsm_pkg::ST_LOADED : dsm_pkg::ST_BAD_ADDR;
            else if (opcode == dsm_pkg::CMD_EXEC && halted_reg)
                status_reg <= dsm_pkg::ST_HALTED;
            else
                status_reg <= dsm_pkg::ST_OK;
        end
        if (state_reg == S_F1)
        begin
            instr_reg  <= pm_q;
            opbyte_reg <= pm_q[7:0];
            tos_reg    <= (dp_reg == '0) ? '0 : ds_q;
        end
        if (state_reg == S_F2)
        begin
            nos_reg  <= (dp_reg >= DPW'(1)) ? ds_q : '0;
            lit_reg  <= pm_q;
            rtop_reg <= rs_q;
        end
        if (state_reg == S_F3)
        begin
            third_reg <= (dp_reg >= DPW'(2)) ? ds_q : '0;
            fetch_reg <= pm_q;
        end
        if (state_reg == S_DEC)
        begin
            status_reg <= d_status;
            dwe_reg    <= d_we;
            dwa_reg[0] <= d_wa[0];
            dwa_reg[1] <= d_wa[1];
            dwa_reg[2] <= d_wa[2];
            dwd_reg[0] <= d_wd[0];
            dwd_reg[1] <= d_wd[1];
            dwd_reg[2] <= d_wd[2];
            rwe_reg    <= (op == dsm_pkg::OP_PUSH) || (op == dsm_pkg::OP_CALL)
                       || (op == dsm_pkg::OP_IF);
            rwa_reg    <= rp_reg + RPW'(1);
            rwd_reg    <= (op == dsm_pkg::OP_PUSH) ? tos_reg : W'(ip_reg);
            pwe_reg    <= (op == dsm_pkg::OP_STORE);
            pwa_reg    <= AW'(tos_reg);
            pwd_reg    <= nos_reg;
        end
        if (state_reg == S_ALU && alu_stat.done)
        begin
            dwd_reg[0] <= alu_res;
            if (op == dsm_pkg::OP_DIVMOD)
                dwd_reg[1] <= alu_res_hi;
        end
        if (state_reg == S_TOP1)
            top_reg <= (dp_reg == '0) ? '0 : ds_q;
    end

    assign busy            = (state_reg != S_IDLE);
    assign done            = done_reg;
    assign status          = status_reg;
    assign executed_opcode = opbyte_reg;
    assign next_ip         = 14'(ip_reg);
    assign top_of_stack    = 32'($signed(top_reg));
    assign data_depth      = 6'(dp_reg);
    assign return_depth    = 8'(rp_reg);

    `DSM_ASSERT_NOW(a_done_idle, clk, rst_n, done, !busy, "result beat while busy")
    `DSM_ASSERT_NEXT(a_take_busy, clk, rst_n, start && !busy, busy, "item taken but not busy")
    `DSM_ASSERT_NOW(a_dp_range, clk, rst_n, 1'b1, dp_reg <= DPW'(DATA_DEPTH), "data sp range")
    `DSM_ASSERT_NOW(a_rp_range, clk, rst_n, 1'b1, rp_reg <= RPW'(RETURN_DEPTH),
        "return sp range")

endmodule
`default_nettype wire

@@ test/testbench.sv @@
// Self-checking testbench for dual_stack_machine_core.
// Needs dsm_pkg and the core RTL; a built-in machine predictor checks every result.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
    import dsm_pkg::*;

    localparam int MEM_WORDS   = 16384;
    localparam int DSTK_DEPTH  = 32;
    localparam int RSTK_DEPTH  = 128;
    localparam int ITEM_TARGET = 1050;
    localparam int CYCLE_LIMIT = 1000000;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct {
        logic [3:0]  status;
        logic [7:0]  opbyte;
        logic [13:0] ip;
        logic [31:0] tos;
        logic [5:0]  ddepth;
        logic [7:0]  rdepth;
    } machine_result_t;

    typedef struct {
        logic [1:0]  cmd;
        logic [13:0] addr;
        logic [31:0] word;
        bit          fixed;
        logic [3:0]  status;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  opcode;
    logic [13:0] load_address;
    logic signed [31:0] load_word;
    logic        done;
    logic [3:0]  status;
    logic [7:0]  executed_opcode;
    logic [13:0] next_ip;
    logic signed [31:0] top_of_stack;
    logic [5:0]  data_depth;
    logic [7:0]  return_depth;

    dual_stack_machine_core u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .opcode(opcode), .load_address(load_address), .load_word(load_word),
        .done(done), .status(status), .executed_opcode(executed_opcode),
        .next_ip(next_ip), .top_of_stack(top_of_stack),
        .data_depth(data_depth), .return_depth(return_depth)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // machine state mirror
    logic [31:0] pmem [MEM_WORDS];
    logic [31:0] dstk [DSTK_DEPTH + 1];
    logic [31:0] rstk [RSTK_DEPTH + 1];
    int          ipr, dp, rp;
    bit          halted;

    // per opcode: data needed, return needed, data change, return change
    int need_d [27] = '{0,0,1,1,2,1,0,1,1,3,0,2,2,2,2,1,2,2,2,2,2,2,2,2,2,1,0};
    int need_r [27] = '{0,0,0,0,0,0,1,0,0,0,1,0,0,0,0,0,0,0,0,0,0,0,0,0,0,0,0};
    int chg_d  [27] = '{0,1,1,-1,0,-1,1,-1,-1,-3,0,-1,-1,-1,-1,0,-2,-1,-1,-1,0,-1,-1,-1,-1,0,0};
    int chg_r  [27] = '{0,0,0,0,0,1,-1,0,1,1,-1,0,0,0,0,0,0,0,0,0,0,0,0,0,0,0,0};

    machine_result_t expected_results[$];
    int  n_items;
    int  burst_left;
    int  cycles;
    bit  failed;

    function automatic void pop_data();
        if (dp >= 1) begin
            dstk[dp] = '0;
            dp--;
        end
    endfunction

    function automatic void push_data(input logic [31:0] v);
        if (dp < DSTK_DEPTH) begin
            dp++;
            dstk[dp] = v;
        end
    endfunction

    function automatic logic [31:0] shift_word(input logic [31:0] b, input logic [31:0] a);
        logic [31:0] m;
        if (a[31]) begin
            m = -a;
            return (m >= 32) ? 32'd0 : b << m;
        end
        if (a >= 32)
            return {32{b[31]}};
        return $signed(b) >>> a;
    endfunction

    function automatic logic [3:0] run_instr(output logic [7:0] opb);
        int s, r, nd, nr, dd, dr, nip;
        logic [31:0] w, tos, nos, third, target, ma, mb, q, rm;
        logic [4:0] op;
        bit jump;
        s = dp;
        r = rp;
        jump = 0;
        target = '0;
        w = pmem[ipr];
        opb = w[7:0];
        if (w > 26)
            return ST_BAD_OP;
        op = w[4:0];
        tos = dstk[s];
        nos = (s >= 1) ? dstk[s - 1] : '0;
        third = (s >= 2) ? dstk[s - 2] : '0;
        nd = need_d[op];
        nr = need_r[op];
        dd = chg_d[op];
        dr = chg_r[op];
        if (op == OP_ZRET && tos == 0 && s >= 1) begin
            nr = 1;
            dd = -1;
            dr = -1;
        end
        if (s < nd) return ST_UNDER;
        if (r < nr) return ST_RET_ERR;
        if (s + dd > DSTK_DEPTH) return ST_OVER;
        if (r + dr > RSTK_DEPTH) return ST_RET_ERR;
        if (op == OP_DIVMOD && tos == 0) return ST_DIV_ZERO;
        if (op == OP_LIT && ipr + 1 >= MEM_WORDS) return ST_BAD_ADDR;
        if ((op == OP_FETCH || op == OP_STORE) && tos >= MEM_WORDS) return ST_BAD_ADDR;
        if (op == OP_JUMP || op == OP_CALL) begin
            target = tos;
            jump = 1;
        end
        if (op == OP_IF) begin
            target = (third != 0) ? nos : tos;
            jump = 1;
        end
        if (op == OP_RETURN || (op == OP_ZRET && dr < 0)) begin
            target = rstk[r] + 1;
            jump = 1;
        end
        if (jump && target >= MEM_WORDS) return ST_BAD_ADDR;

        case (op)
            OP_LIT:    push_data(pmem[ipr + 1]);
            OP_DUP:    push_data(tos);
            OP_DROP:   pop_data();
            OP_SWAP:
            begin
                dstk[s] = nos;
                dstk[s - 1] = tos;
            end
            OP_PUSH:
            begin
                rstk[r + 1] = tos;
                rp = r + 1;
                pop_data();
            end
            OP_POP:
            begin
                push_data(rstk[r]);
                rp = r - 1;
            end
            OP_JUMP:   pop_data();
            OP_CALL:
            begin
                rstk[r + 1] = ipr;
                rp = r + 1;
                pop_data();
            end
            OP_IF:
            begin
                rstk[r + 1] = ipr;
                rp = r + 1;
                pop_data();
                pop_data();
                pop_data();
            end
            OP_RETURN: rp = r - 1;
            OP_EQ:     begin dstk[s - 1] = {32{nos == tos}}; pop_data(); end
            OP_NEQ:    begin dstk[s - 1] = {32{nos != tos}}; pop_data(); end
            OP_LT:     begin dstk[s - 1] = {32{$signed(nos) < $signed(tos)}}; pop_data(); end
            OP_GT:     begin dstk[s - 1] = {32{$signed(tos) < $signed(nos)}}; pop_data(); end
            OP_FETCH:  dstk[s] = pmem[tos[13:0]];
            OP_STORE:
            begin
                pmem[tos[13:0]] = nos;
                pop_data();
                pop_data();
            end
            OP_ADD:    begin dstk[s - 1] = nos + tos; pop_data(); end
            OP_SUB:    begin dstk[s - 1] = nos - tos; pop_data(); end
            OP_MUL:    begin dstk[s - 1] = nos * tos; pop_data(); end
            OP_DIVMOD:
            begin
                ma = tos[31] ? -tos : tos;
                mb = nos[31] ? -nos : nos;
                q = mb / ma;
                rm = mb % ma;
                if (tos[31] != nos[31]) q = -q;
                if (nos[31]) rm = -rm;
                dstk[s] = q;
                dstk[s - 1] = rm;
            end
            OP_AND:    begin dstk[s - 1] = nos & tos; pop_data(); end
            OP_OR:     begin dstk[s - 1] = nos | tos; pop_data(); end
            OP_XOR:    begin dstk[s - 1] = nos ^ tos; pop_data(); end
            OP_SHIFT:  begin dstk[s - 1] = shift_word(nos, tos); pop_data(); end
            OP_ZRET:
            begin
                if (dr < 0) begin
                    pop_data();
                    rp = r - 1;
                end
            end
            OP_END:
            begin
                halted = 1;
                return ST_ENDED;
            end
            default: ;
        endcase

        if (jump) begin
            ipr = target;
            return ST_OK;
        end
        nip = ipr + ((op == OP_LIT) ? 2 : 1);
        if (nip >= MEM_WORDS) begin
            halted = 1;
            return ST_ENDED;
        end
        ipr = nip;
        return ST_OK;
    endfunction

    function automatic machine_result_t machine_step(input logic [1:0] cmd,
                                                     input logic [13:0] addr,
                                                     input logic [31:0] word);
        machine_result_t res;
        res.status = ST_OK;
        res.opbyte = '0;
        case (cmd)
            CMD_LOAD:
            begin
                pmem[addr] = word;
                res.status = ST_LOADED;
            end
            CMD_EXEC:
            begin
                if (halted)
                    res.status = ST_HALTED;
                else begin
                    res.status = run_instr(res.opbyte);
                    if (res.status >= ST_UNDER)
                        halted = 1;
                end
            end
            CMD_RESTART:
            begin
                ipr = 0;
                dp = 0;
                rp = 0;
                halted = 0;
            end
            default: ;
        endcase
        res.ip = ipr;
        res.tos = dstk[dp];
        res.ddepth = dp;
        res.rdepth = rp;
        return res;
    endfunction

    // drive one beat, record its expected result once taken
    task automatic issue(input logic [1:0] cmd, input logic [13:0] addr,
                         input logic [31:0] word, input bit fixed, input logic [3:0] st);
        machine_result_t res;
        opcode = cmd;
        load_address = addr;
        load_word = word;
        start = 1'b1;
        do
            @(posedge clk);
        while (busy);
        res = machine_step(cmd, addr, word);
        if (fixed)
            res.status = st;
        expected_results.push_back(res);
        n_items++;
        @(negedge clk);
        if (burst_left == 0) begin
            start = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 6);
        end
        else
            burst_left--;
    endtask

    function automatic logic [31:0] pick_data(input int lo, input int hi);
        case ($urandom_range(0, 7))
            0, 1, 2, 3: return $urandom_range(lo, hi);
            4: return 32'h8000_0000;
            5: return 32'h7fff_ffff;
            6: return {$urandom_range(0, 1) ? 27'h7ff_ffff : 27'd0, 5'($urandom_range(0, 31))};
            default: return $urandom;
        endcase
    endfunction

    // random program: a jump to base, then a body of mostly valid instructions, then executes
    task automatic run_program();
        int len, base, steps, k;
        logic [31:0] w;
        len = $urandom_range(4, 24);
        base = ($urandom_range(0, 5) == 0) ? MEM_WORDS - len : 3;
        issue(CMD_LOAD, 0, OP_LIT, 0, 0);
        issue(CMD_LOAD, 1, base, 0, 0);
        issue(CMD_LOAD, 2, OP_JUMP, 0, 0);
        k = 0;
        while (k < len) begin
            if ($urandom_range(0, 2) == 0 && k + 1 < len) begin
                issue(CMD_LOAD, base + k, OP_LIT, 0, 0);
                issue(CMD_LOAD, base + k + 1, pick_data(0, base + len + 2), 0, 0);
                k += 2;
            end
            else begin
                w = ($urandom_range(0, 24) == 0) ? $urandom : $urandom_range(0, 26);
                issue(CMD_LOAD, base + k, w, 0, 0);
                k++;
            end
        end
        if ($urandom_range(0, 4) == 0)
            issue(CMD_LOAD, 14'($urandom), $urandom, 0, 0);
        if ($urandom_range(0, 9) == 0)
            issue(CMD_UNUSED, 14'($urandom), $urandom, 0, 0);
        if ($urandom_range(0, 7) != 0)
            issue(CMD_RESTART, 14'($urandom), $urandom, 0, 0);
        steps = ($urandom_range(0, 5) == 0) ? 300 : $urandom_range(len, 3 * len);
        for (int i = 0; i < steps && !halted; i++)
            issue(CMD_EXEC, 14'($urandom), $urandom, 0, 0);
        if ($urandom_range(0, 2) == 0)
            issue(CMD_EXEC, 0, 0, 0, 0);
    endtask

    stim_row_t directed [] = '{
        '{CMD_EXEC,    14'd0,     32'd0,         1, ST_OK},
        '{CMD_UNUSED,  14'h3fff,  32'hffff_ffff, 1, ST_OK},
        '{CMD_LOAD,    14'd0,     OP_LIT,        1, ST_LOADED},
        '{CMD_LOAD,    14'd1,     32'h8000_0000, 1, ST_LOADED},
        '{CMD_LOAD,    14'd2,     OP_LIT,        1, ST_LOADED},
        '{CMD_LOAD,    14'd3,     32'hffff_ffff, 1, ST_LOADED},
        '{CMD_LOAD,    14'd4,     OP_DIVMOD,     1, ST_LOADED},
        '{CMD_LOAD,    14'd5,     OP_LIT,        1, ST_LOADED},
        '{CMD_LOAD,    14'd6,     32'hffff_ffd8, 1, ST_LOADED},
        '{CMD_LOAD,    14'd7,     OP_SHIFT,      1, ST_LOADED},
        '{CMD_LOAD,    14'd8,     32'hffff_ffff, 1, ST_LOADED},
        '{CMD_LOAD,    14'h3fff,  OP_LIT,        1, ST_LOADED},
        '{CMD_RESTART, 14'd0,     32'd0,         1, ST_OK},
        '{CMD_EXEC,    14'd0,     32'd0,         0, ST_OK},
        '{CMD_EXEC,    14'd0,     32'd0,         0, ST_OK},
        '{CMD_EXEC,    14'd0,     32'd0,         0, ST_OK},  // min / -1 wraps
        '{CMD_EXEC,    14'd0,     32'd0,         0, ST_OK},
        '{CMD_EXEC,    14'd0,     32'd0,         0, ST_OK},  // left shift by 40
        '{CMD_EXEC,    14'd0,     32'd0,         1, ST_BAD_OP},
        '{CMD_EXEC,    14'd0,     32'd0,         1, ST_HALTED},
        '{CMD_LOAD,    14'd0,     OP_DROP,       1, ST_LOADED},
        '{CMD_RESTART, 14'd0,     32'd0,         1, ST_OK},
        '{CMD_EXEC,    14'd0,     32'd0,         1, ST_UNDER}
    };

    always @(posedge clk)
    begin
        machine_result_t exp_r;
        if (rst_n && done) begin
            if (expected_results.size() == 0) begin
                $error("result with no beat pending");
                failed = 1;
            end
            else begin
                exp_r = expected_results.pop_front();
                if (status !== exp_r.status) begin
                    $error("status exp %0d got %0d", exp_r.status, status);
                    failed = 1;
                end
                if (executed_opcode !== exp_r.opbyte) begin
                    $error("executed_opcode exp %0d got %0d", exp_r.opbyte, executed_opcode);
                    failed = 1;
                end
                if (next_ip !== exp_r.ip) begin
                    $error("next_ip exp %0d got %0d", exp_r.ip, next_ip);
                    failed = 1;
                end
                if (top_of_stack !== exp_r.tos) begin
                    $error("top_of_stack exp %h got %h", exp_r.tos, top_of_stack);
                    failed = 1;
                end
                if (data_depth !== exp_r.ddepth) begin
                    $error("data_depth exp %0d got %0d", exp_r.ddepth, data_depth);
                    failed = 1;
                end
                if (return_depth !== exp_r.rdepth) begin
                    $error("return_depth exp %0d got %0d", exp_r.rdepth, return_depth);
                    failed = 1;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        int drain;
        rst_n = 1'b0;
        start = 1'b0;
        opcode = CMD_LOAD;
        load_address = '0;
        load_word = '0;
        failed = 0;
        n_items = 0;
        burst_left = 0;
        cycles = 0;
        for (int i = 0; i < MEM_WORDS; i++) pmem[i] = '0;
        for (int i = 0; i <= DSTK_DEPTH; i++) dstk[i] = '0;
        for (int i = 0; i <= RSTK_DEPTH; i++) rstk[i] = '0;
        ipr = 0;
        dp = 0;
        rp = 0;
        halted = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed[i])
            issue(directed[i].cmd, directed[i].addr, directed[i].word,
                  directed[i].fixed, directed[i].status);
        while (n_items < ITEM_TARGET)
            run_program();

        @(negedge clk);
        start = 1'b0;
        drain = 0;
        while (expected_results.size() != 0 && drain < 5000) begin
            @(posedge clk);
            drain++;
        end
        repeat (60) @(posedge clk);
        if (!failed && expected_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
`default_nettype wire
